// ----- design/bcd_calendar_to_unix_time_defines.svh -----
// Assertion macros for the BCD calendar to Unix time converter.
// Included by the top level; no other dependencies.
`ifndef BCD_CALENDAR_TO_UNIX_TIME_DEFINES_SVH
`define BCD_CALENDAR_TO_UNIX_TIME_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define BCDUT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcdut assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define BCDUT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcdut assertion failed");
`else
`define BCDUT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BCDUT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/bcdut_pkg.sv -----
// Shared constants, stage payload types and the month table of the converter.
// No dependencies; imported by every module of the block.
package bcdut_pkg;

  localparam logic [31:0] SECS_MIN  = 32'h0000_003C;
  localparam logic [31:0] SECS_HOUR = 32'h0000_0E10;
  localparam logic [31:0] SECS_DAY  = 32'h0001_5180;
  localparam logic [31:0] SECS_YEAR = 32'h01E1_3380;

  // Offset from 1970 to 2000, added to the two-digit year.
  localparam logic [7:0] CENTURY_OFFSET = 8'd30;
  // Two-digit year of 2100, the only non-leap multiple of four in range.
  localparam logic [7:0] YEAR_2100      = 8'd100;
  localparam logic [7:0] MONTH_LAST     = 8'd12;
  localparam logic [7:0] MONTH_FEB      = 8'd1;

  typedef struct packed {
    logic [7:0] yy;
    logic [7:0] mon;
    logic [7:0] day;
    logic [5:0] hour;
    logic [6:0] mins;
    logic [6:0] secs;
  } dec_t;

  typedef struct packed {
    logic [7:0] yoff;
    logic [9:0] days;
    logic [5:0] hour;
    logic [6:0] mins;
    logic [6:0] secs;
  } days_t;

  typedef struct packed {
    logic [31:0] yr_sec;
    logic [31:0] day_sec;
    logic [17:0] hms_sec;
  } prod_t;

  // Days of the whole months before month index m; index 12 counts the full year.
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

// ----- design/bcd_calendar_to_unix_time.sv -----
// BCD calendar to Unix time converter, top level; uses bcdut_pkg, the stage
// modules bcdut_decode, bcdut_days, bcdut_scale and the assertion header.
// Four register stages (decode, day count, multiply, final add) lie between an
// accepted input beat and out_tvalid.
// Throughput: one beat per cycle; a stalled output holds back only the stages behind it.
// Reset (rst_n low, synchronous) empties every stage; payload registers are not reset.
`include "bcd_calendar_to_unix_time_defines.svh"
module bcd_calendar_to_unix_time (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata fields from bit 0: date_word [23:0], time_word [46:24], zero [47].
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // out_tdata fields from bit 0: epoch_seconds [31:0].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata
);
  import bcdut_pkg::*;

  // Handshake between stages: each stage is ready when it is empty or when the
  // stage after it is ready, so a full pipeline moves as a whole while out_tready is high.
  logic  s1_valid, s1_ready;
  dec_t  s1_data;
  logic  s2_valid, s2_ready;
  days_t s2_data;
  logic  s3_valid, s3_ready;
  prod_t s3_data;

  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic [31:0] epoch_nxt;

  bcdut_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_tvalid),
    .up_ready  (in_tready),
    .date_word (in_tdata[23:0]),
    .time_word (in_tdata[46:24]),
    .dn_valid  (s1_valid),
    .dn_ready  (s1_ready),
    .dn_data   (s1_data)
  );

  bcdut_days u_days (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  bcdut_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_data  (s3_data)
  );

  // Final stage: the three partial second counts are summed modulo 2^32 into
  // the output register, which doubles as the slot that parts the two sides.
  assign epoch_nxt = s3_data.yr_sec + s3_data.day_sec + 32'(s3_data.hms_sec);
  assign s3_ready  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_ready) begin
      out_valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s3_valid) begin
      out_data_r <= epoch_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // With the output empty nothing can hold the pipeline back.
  `BCDUT_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)
  // An accepted input beat is in the decode stage on the next cycle.
  `BCDUT_ASSERT_NEXT(a_beat_enters, clk, rst_n, in_tvalid && in_tready, s1_valid)
  // A taken result with nothing behind it leaves the output empty.
  `BCDUT_ASSERT_NEXT(a_drain, clk, rst_n, out_tvalid && out_tready && !s3_valid, !out_tvalid)

endmodule

// ----- design/bcdut_decode.sv -----
// First pipeline stage: BCD digit decoding of the date and time words.
// Depends on bcdut_pkg.
module bcdut_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic [23:0]        date_word,
  input  logic [22:0]        time_word,
  output logic               dn_valid,
  input  logic               dn_ready,
  output bcdut_pkg::dec_t    dn_data
);
  import bcdut_pkg::*;

  logic valid_r;
  dec_t data_r;
  dec_t data_nxt;

  // Digits are weighted tens * 10 + units with no range check.
  always_comb begin
    data_nxt.yy   = 8'(date_word[23:20]) * 8'd10 + 8'(date_word[19:16]);
    data_nxt.mon  = 8'(date_word[12]) * 8'd10 + 8'(date_word[11:8]) - 8'd1;
    data_nxt.day  = 8'(date_word[5:4]) * 8'd10 + 8'(date_word[3:0]) - 8'd1;
    data_nxt.hour = 6'(time_word[21:20]) * 6'd10 + 6'(time_word[19:16]);
    data_nxt.mins = 7'(time_word[14:12]) * 7'd10 + 7'(time_word[11:8]);
    data_nxt.secs = 7'(time_word[6:4]) * 7'd10 + 7'(time_word[3:0]);
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- design/bcdut_days.sv -----
// Second pipeline stage: year offset, leap-day count and day-of-epoch sum.
// Depends on bcdut_pkg.
module bcdut_days (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  bcdut_pkg::dec_t    up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output bcdut_pkg::days_t   dn_data
);
  import bcdut_pkg::*;

  logic       valid_r;
  days_t      data_r;
  days_t      data_nxt;
  logic [7:0] yoff;
  logic       leap;
  logic [3:0] mon_idx;

  always_comb begin
    yoff    = up_data.yy + CENTURY_OFFSET;
    // Within 2000 to 2165 only 2100 breaks the every-fourth-year rule.
    leap    = (up_data.yy[1:0] == 2'd0) && (up_data.yy != YEAR_2100);
    mon_idx = (up_data.mon > MONTH_LAST) ? MONTH_LAST[3:0] : up_data.mon[3:0];
    data_nxt.yoff = yoff;
    data_nxt.days = 10'(yoff[7:2])
                  + 10'(yoff[1:0] == 2'd3)
                  + 10'(leap && (up_data.mon > MONTH_FEB))
                  + 10'(days_before_month(mon_idx))
                  + 10'(up_data.day);
    data_nxt.hour = up_data.hour;
    data_nxt.mins = up_data.mins;
    data_nxt.secs = up_data.secs;
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- design/bcdut_scale.sv -----
// Third pipeline stage: constant multiplications into seconds.
// Depends on bcdut_pkg.
module bcdut_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  bcdut_pkg::days_t   up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output bcdut_pkg::prod_t   dn_data
);
  import bcdut_pkg::*;

  logic  valid_r;
  prod_t data_r;
  prod_t data_nxt;

  // The year product exceeds 32 bits for late years; the low word is kept.
  always_comb begin
    data_nxt.yr_sec  = 32'(up_data.yoff) * SECS_YEAR;
    data_nxt.day_sec = 32'(up_data.days) * SECS_DAY;
    data_nxt.hms_sec = 18'(32'(up_data.hour) * SECS_HOUR)
                     + 18'(32'(up_data.mins) * SECS_MIN)
                     + 18'(up_data.secs);
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule
